/* rtl/tcwf_pkg.sv */
package tcwf_pkg;

  localparam int unsigned BYTE_BITS  = 8;
  localparam int unsigned TOTAL_BITS = 24;
  localparam int unsigned SLOTS      = 3;

  localparam logic [BYTE_BITS-1:0] CH_NUL       = 8'h00;
  localparam logic [BYTE_BITS-1:0] CH_TAB       = 8'h09;
  localparam logic [BYTE_BITS-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [BYTE_BITS-1:0] CH_VTAB      = 8'h0B;
  localparam logic [BYTE_BITS-1:0] CH_FORMFEED  = 8'h0C;
  localparam logic [BYTE_BITS-1:0] CH_RETURN    = 8'h0D;
  localparam logic [BYTE_BITS-1:0] CH_SPACE     = 8'h20;
  localparam logic [BYTE_BITS-1:0] CH_HASH      = 8'h23;
  localparam logic [BYTE_BITS-1:0] CH_BACKSLASH = 8'h5C;

  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_HELD  = 2'd1,
    ESC_SPACE = 2'd2
  } esc_t;

  // slot 0 backslash, slot 1 space, slot 2 main result
  typedef struct packed {
    logic [SLOTS-1:0]      mask;
    logic [BYTE_BITS-1:0]  main_byte;
    logic                  main_end;
    logic [TOTAL_BITS-1:0] total;
  } group_t;

  function automatic logic is_hspace(input logic [BYTE_BITS-1:0] b);
    is_hspace = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VTAB) ||
                (b == CH_FORMFEED) || (b == CH_RETURN);
  endfunction

endpackage

/* rtl/tcwf_if.sv */
interface tcwf_in_if;
  logic                           valid;
  logic                           ready;
  logic [tcwf_pkg::BYTE_BITS-1:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface tcwf_out_if;
  logic                            valid;
  logic                            ready;
  logic [tcwf_pkg::BYTE_BITS-1:0]  out_byte;
  logic [tcwf_pkg::TOTAL_BITS-1:0] newline_total;
  logic                            end_of_text;
  logic                            last_of_run;

  modport source (output valid, output out_byte, output newline_total,
                  output end_of_text, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input newline_total,
                  input end_of_text, input last_of_run, output ready);
endinterface

/* rtl/tcwf_core.sv */
module tcwf_core #(
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [tcwf_pkg::BYTE_BITS-1:0] in_byte,
  output logic                           in_ready,
  input  logic                           can_take,
  output logic                           load,
  output tcwf_pkg::group_t               grp
);

  logic                           s1_valid;
  logic [tcwf_pkg::BYTE_BITS-1:0] s1_byte;

  logic                  space_pending, space_pending_next;
  logic                  inside_comment, inside_comment_next;
  tcwf_pkg::esc_t        escape_phase, escape_phase_next;
  logic                  emitted_any, emitted_any_next;
  logic                  last_was_newline, last_was_newline_next;
  logic [COUNT_BITS-1:0] newline_counter, newline_counter_next;

  logic                  proceed;
  logic                  flush_bs;
  logic                  flush_sp;
  logic                  main_emit;
  logic                  main_end;
  logic [tcwf_pkg::BYTE_BITS-1:0] main_byte;
  logic                  em_mid;
  logic                  lnl_mid;
  logic [COUNT_BITS-1:0] count_out;

  assign load     = s1_valid && can_take;
  assign in_ready = !s1_valid || can_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_byte <= in_byte;
    end
  end

  always_comb begin
    proceed               = 1'b1;
    flush_bs              = 1'b0;
    flush_sp              = 1'b0;
    main_emit             = 1'b0;
    main_end              = 1'b0;
    main_byte             = s1_byte;
    space_pending_next    = space_pending;
    inside_comment_next   = inside_comment;
    escape_phase_next     = escape_phase;
    emitted_any_next      = emitted_any;
    last_was_newline_next = last_was_newline;
    newline_counter_next  = newline_counter;

    if (inside_comment) begin
      if (s1_byte == tcwf_pkg::CH_NEWLINE) begin
        inside_comment_next = 1'b0;
      end else if (s1_byte != tcwf_pkg::CH_NUL) begin
        proceed = 1'b0;
      end
    end else if (escape_phase != tcwf_pkg::ESC_NONE) begin
      if (s1_byte == tcwf_pkg::CH_NEWLINE) begin
        escape_phase_next = tcwf_pkg::ESC_NONE;
        proceed = 1'b0;
      end else if (tcwf_pkg::is_hspace(s1_byte)) begin
        escape_phase_next = tcwf_pkg::ESC_SPACE;
        proceed = 1'b0;
      end else begin
        flush_bs           = 1'b1;
        flush_sp           = (escape_phase == tcwf_pkg::ESC_SPACE);
        space_pending_next = flush_sp;
        escape_phase_next  = tcwf_pkg::ESC_NONE;
      end
    end

    em_mid  = emitted_any | flush_bs;
    lnl_mid = flush_bs ? 1'b0 : last_was_newline;
    emitted_any_next      = em_mid;
    last_was_newline_next = lnl_mid;

    if (proceed) begin
      if (s1_byte == tcwf_pkg::CH_NUL) begin
        main_emit = 1'b1;
        main_end  = 1'b1;
        main_byte = tcwf_pkg::CH_NUL;
      end else if (s1_byte == tcwf_pkg::CH_BACKSLASH) begin
        escape_phase_next = tcwf_pkg::ESC_HELD;
      end else if (s1_byte == tcwf_pkg::CH_HASH) begin
        inside_comment_next = 1'b1;
        space_pending_next  = 1'b0;
      end else if (s1_byte == tcwf_pkg::CH_NEWLINE) begin
        if (em_mid && !lnl_mid) begin
          main_emit = 1'b1;
          emitted_any_next      = 1'b1;
          last_was_newline_next = 1'b1;
          if (newline_counter != '1) begin
            newline_counter_next = newline_counter + 1'b1;
          end
        end
      end else if (tcwf_pkg::is_hspace(s1_byte)) begin
        if (!space_pending_next) begin
          main_emit = 1'b1;
          main_byte = tcwf_pkg::CH_SPACE;
          space_pending_next    = 1'b1;
          emitted_any_next      = 1'b1;
          last_was_newline_next = 1'b0;
        end
      end else begin
        main_emit = 1'b1;
        space_pending_next    = 1'b0;
        emitted_any_next      = 1'b1;
        last_was_newline_next = 1'b0;
      end
    end

    count_out = newline_counter_next;

    // end of text returns the whole state to its reset value
    if (main_end) begin
      space_pending_next    = 1'b0;
      inside_comment_next   = 1'b0;
      escape_phase_next     = tcwf_pkg::ESC_NONE;
      emitted_any_next      = 1'b0;
      last_was_newline_next = 1'b0;
      newline_counter_next  = '0;
    end
  end

  always_comb begin
    grp.mask      = {main_emit, flush_sp, flush_bs};
    grp.main_byte = main_byte;
    grp.main_end  = main_end;
    grp.total     = tcwf_pkg::TOTAL_BITS'(count_out);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      space_pending    <= 1'b0;
      inside_comment   <= 1'b0;
      escape_phase     <= tcwf_pkg::ESC_NONE;
      emitted_any      <= 1'b0;
      last_was_newline <= 1'b0;
      newline_counter  <= '0;
    end else if (load) begin
      space_pending    <= space_pending_next;
      inside_comment   <= inside_comment_next;
      escape_phase     <= escape_phase_next;
      emitted_any      <= emitted_any_next;
      last_was_newline <= last_was_newline_next;
      newline_counter  <= newline_counter_next;
    end
  end

endmodule

/* rtl/tcwf_burst.sv */
module tcwf_burst (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  tcwf_pkg::group_t        grp,
  output logic                    can_take,
  tcwf_out_if.source              res
);

  logic [tcwf_pkg::SLOTS-1:0]      mask;
  logic [tcwf_pkg::BYTE_BITS-1:0]  main_byte;
  logic                            main_end;
  logic [tcwf_pkg::TOTAL_BITS-1:0] total;

  logic [tcwf_pkg::SLOTS-1:0] low_bit;
  logic [tcwf_pkg::SLOTS-1:0] mask_next;
  logic                       take;

  assign low_bit   = mask & (~mask + 1'b1);
  assign take      = res.valid && res.ready;
  assign mask_next = take ? (mask & ~low_bit) : mask;
  assign can_take  = (mask_next == '0);

  assign res.valid         = |mask;
  assign res.out_byte      = mask[0] ? tcwf_pkg::CH_BACKSLASH :
                             mask[1] ? tcwf_pkg::CH_SPACE : main_byte;
  assign res.newline_total = total;
  assign res.end_of_text   = !mask[0] && !mask[1] && main_end;
  assign res.last_of_run   = (mask & ~low_bit) == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (load) begin
      mask <= grp.mask;
    end else begin
      mask <= mask_next;
    end
    if (load) begin
      main_byte <= grp.main_byte;
      main_end  <= grp.main_end;
      total     <= grp.total;
    end
  end

endmodule

/* rtl/text_comment_whitespace_filter_unit.sv */
// channel    dir  payload                                          transaction
// text_in    in   text_byte[7:0]                                   one input byte
// result_out out  out_byte[7:0] newline_total[23:0] end_of_text    one result byte
//                 last_of_run
// a byte is registered, decoded in the next cycle and its zero to three results
// are held in a result register that shows one result per cycle while result_out is ready
// throughput is one byte per cycle while each byte yields at most one result and result_out is ready;
// a byte that flushes a held backslash and space occupies the result register
// until all of its results, up to three, have been taken
// rst is synchronous and clears the filter state and both valid flags
module text_comment_whitespace_filter_unit #(
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic          clk,
  input  logic          rst,
  tcwf_in_if.sink       text_in,
  tcwf_out_if.source    result_out
);

  tcwf_pkg::group_t grp;
  logic             load;
  logic             can_take;

  tcwf_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (text_in.valid),
    .in_byte  (text_in.text_byte),
    .in_ready (text_in.ready),
    .can_take (can_take),
    .load     (load),
    .grp      (grp)
  );

  tcwf_burst u_burst (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .grp      (grp),
    .can_take (can_take),
    .res      (result_out)
  );

endmodule

/* dv/text_comment_whitespace_filter_unit_tb.sv */
module text_comment_whitespace_filter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcwf_pkg::*;

  localparam int unsigned CNT_BITS = 8;
  localparam logic [TOTAL_BITS-1:0] NL_MAX = TOTAL_BITS'((64'd1 << CNT_BITS) - 1);
  localparam int QUIET_TAIL = 40;

  typedef struct packed {
    logic [BYTE_BITS-1:0] ch;
    logic                 wait_drain;
  } text_item_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0]  ch;
    logic [TOTAL_BITS-1:0] total;
    logic                  eot;
    logic                  last;
  } clean_byte_t;

  logic clk;
  logic rst = 1'b1;

  tcwf_in_if  in_bus ();
  tcwf_out_if out_bus ();

  text_comment_whitespace_filter_unit #(
    .COUNT_BITS(CNT_BITS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .text_in   (in_bus),
    .result_out(out_bus)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  text_item_t  text_queue[$];
  clean_byte_t clean_queue[$];
  int          fails = 0;

  // filter state mirror
  logic                  sp_pend;
  logic                  in_comment;
  esc_t                  esc;
  logic                  any_out;
  logic                  last_nl;
  logic [TOTAL_BITS-1:0] nl_count;

  function automatic logic is_blank(input logic [BYTE_BITS-1:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_VTAB || b == CH_FORMFEED ||
           b == CH_RETURN;
  endfunction

  function automatic logic [BYTE_BITS-1:0] pick_blank();
    case ($urandom_range(0, 4))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_VTAB;
      3: return CH_FORMFEED;
      default: return CH_RETURN;
    endcase
  endfunction

  task automatic clear_filter();
    sp_pend    = 1'b0;
    in_comment = 1'b0;
    esc        = ESC_NONE;
    any_out    = 1'b0;
    last_nl    = 1'b0;
    nl_count   = '0;
  endtask

  task automatic emit(input logic [BYTE_BITS-1:0] b, input logic eot);
    clean_byte_t r;
    if (!eot) begin
      if (b == CH_NEWLINE && nl_count < NL_MAX) nl_count++;
      any_out = 1'b1;
      last_nl = (b == CH_NEWLINE);
    end
    r.ch    = eot ? CH_NUL : b;
    r.total = nl_count;
    r.eot   = eot;
    r.last  = 1'b0;
    clean_queue.push_back(r);
  endtask

  task automatic filter_byte(input logic [BYTE_BITS-1:0] b);
    int          first;
    logic        done;
    clean_byte_t tail;
    first = clean_queue.size();
    done  = 1'b0;
    if (in_comment) begin
      if (b == CH_NEWLINE) in_comment = 1'b0;
      else if (b != CH_NUL) done = 1'b1;
    end else if (esc != ESC_NONE) begin
      if (b == CH_NEWLINE) begin
        esc  = ESC_NONE;
        done = 1'b1;
      end else if (is_blank(b)) begin
        esc  = ESC_SPACE;
        done = 1'b1;
      end else begin
        emit(CH_BACKSLASH, 1'b0);
        sp_pend = 1'b0;
        if (esc == ESC_SPACE) begin
          emit(CH_SPACE, 1'b0);
          sp_pend = 1'b1;
        end
        esc = ESC_NONE;
      end
    end
    if (!done) begin
      if (b == CH_NUL) begin
        emit(CH_NUL, 1'b1);
        clear_filter();
      end else if (b == CH_BACKSLASH) begin
        esc = ESC_HELD;
      end else if (b == CH_HASH) begin
        in_comment = 1'b1;
        sp_pend    = 1'b0;
      end else if (b == CH_NEWLINE) begin
        if (any_out && !last_nl) emit(CH_NEWLINE, 1'b0);
      end else if (is_blank(b)) begin
        if (!sp_pend) begin
          emit(CH_SPACE, 1'b0);
          sp_pend = 1'b1;
        end
      end else begin
        emit(b, 1'b0);
        sp_pend = 1'b0;
      end
    end
    if (clean_queue.size() > first) begin
      tail      = clean_queue.pop_back();
      tail.last = 1'b1;
      clean_queue.push_back(tail);
    end
  endtask

  task automatic push_byte(input logic [BYTE_BITS-1:0] b, input logic drain = 1'b0);
    text_item_t t;
    t.ch         = b;
    t.wait_drain = drain;
    text_queue.push_back(t);
  endtask

  task automatic push_random_texts(input int budget);
    int start;
    int len;
    int k;
    start = text_queue.size();
    while (text_queue.size() - start < budget) begin
      len = $urandom_range(1, 16);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 15))
          0, 1, 2, 3, 4, 5: push_byte(BYTE_BITS'($urandom_range(1, 255)));
          6, 7: push_byte(pick_blank());
          8, 9: push_byte(CH_NEWLINE);
          10: begin
            push_byte(CH_HASH);
            k = $urandom_range(0, 4);
            for (int j = 0; j < k; j++) push_byte(BYTE_BITS'($urandom_range(1, 255)));
            if ($urandom_range(0, 3) != 0) push_byte(CH_NEWLINE);
          end
          11, 12: begin
            push_byte(CH_BACKSLASH);
            k = $urandom_range(0, 2);
            for (int j = 0; j < k; j++) push_byte(pick_blank());
            case ($urandom_range(0, 3))
              0, 1: push_byte(CH_NEWLINE);
              2: push_byte(BYTE_BITS'($urandom_range(1, 255)));
              default: push_byte(CH_NUL);
            endcase
          end
          13: begin
            push_byte(CH_BACKSLASH);
            push_byte(CH_BACKSLASH);
          end
          14: push_byte(BYTE_BITS'($urandom_range(0, 255)));
          default: begin
            k = $urandom_range(2, 4);
            for (int j = 0; j < k; j++) push_byte(pick_blank());
          end
        endcase
      end
      if ($urandom_range(0, 7) != 0) push_byte(CH_NUL);
    end
  endtask

  // driver
  int         src_gap;
  text_item_t nxt;

  always @(posedge clk) begin
    if (rst) begin
      in_bus.valid     <= 1'b0;
      in_bus.text_byte <= CH_NUL;
      src_gap = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) filter_byte(in_bus.text_byte);
      if (!in_bus.valid || in_bus.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_bus.valid <= 1'b0;
        end else if (text_queue.size() == 0 ||
                     (text_queue[0].wait_drain && clean_queue.size() != 0)) begin
          in_bus.valid <= 1'b0;
        end else if (text_queue.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
          src_gap = $urandom_range(1, 12) - 1;
          in_bus.valid <= 1'b0;
        end else begin
          nxt = text_queue.pop_front();
          in_bus.valid     <= 1'b1;
          in_bus.text_byte <= nxt.ch;
        end
      end
    end
  end

  // monitor
  int          snk_gap;
  int          hold_left;
  logic        hold_done;
  int          n_results;
  clean_byte_t want;

  task automatic check_result();
    if (clean_queue.size() == 0) begin
      $error("unexpected transaction: out_byte %0h newline_total %0d end_of_text %0b",
             out_bus.out_byte, out_bus.newline_total, out_bus.end_of_text);
      fails++;
    end else begin
      want = clean_queue.pop_front();
      if (out_bus.out_byte !== want.ch) begin
        $error("out_byte: expected %0h, actual %0h", want.ch, out_bus.out_byte);
        fails++;
      end
      if (out_bus.newline_total !== want.total) begin
        $error("newline_total: expected %0d, actual %0d", want.total, out_bus.newline_total);
        fails++;
      end
      if (out_bus.end_of_text !== want.eot) begin
        $error("end_of_text: expected %0b, actual %0b", want.eot, out_bus.end_of_text);
        fails++;
      end
      if (out_bus.last_of_run !== want.last) begin
        $error("last_of_run: expected %0b, actual %0b", want.last, out_bus.last_of_run);
        fails++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_bus.ready <= 1'b0;
      snk_gap   = 0;
      hold_left = 0;
      hold_done = 1'b0;
      n_results = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        check_result();
        n_results++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (!hold_done && n_results >= 100) begin
        // long back-pressure so the input side fills and stalls
        hold_done = 1'b1;
        hold_left = 79;
        out_bus.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        out_bus.ready <= 1'b0;
      end else if (text_queue.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
        snk_gap = $urandom_range(1, 12) - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    in_bus.valid     = 1'b0;
    in_bus.text_byte = CH_NUL;
    out_bus.ready    = 1'b0;
    clear_filter();

    // empty text
    push_byte(CH_NUL);
    // leading newline, whitespace runs, high bytes, comment, line join
    push_byte(CH_NEWLINE);
    push_byte(CH_SPACE);
    push_byte(CH_TAB);
    push_byte(CH_FORMFEED);
    push_byte(8'hFF);
    push_byte(CH_NEWLINE);
    push_byte(CH_NEWLINE);
    push_byte(CH_VTAB);
    push_byte(CH_RETURN);
    push_byte(8'h80);
    push_byte(CH_HASH);
    push_byte(8'h7F);
    push_byte(CH_NEWLINE);
    push_byte(CH_BACKSLASH);
    push_byte(CH_SPACE);
    push_byte(CH_NEWLINE);
    // held backslash and blank flushed before an ordinary byte
    push_byte(CH_BACKSLASH);
    push_byte(CH_RETURN);
    push_byte(8'h01);
    push_byte(CH_BACKSLASH);
    push_byte(CH_BACKSLASH);
    // held backslash and blank flushed at end of text
    push_byte(CH_SPACE);
    push_byte(CH_NUL);
    // end of text inside a comment
    push_byte(CH_HASH);
    push_byte(8'h7A);
    push_byte(CH_NUL);

    push_random_texts(140);
    push_byte(CH_NEWLINE, 1'b1);
    push_random_texts(140);

    push_random_texts(QUIET_TAIL);
    push_byte(CH_NUL);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (text_queue.size() != 0 || in_bus.valid) @(posedge clk);
    while (clean_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fails == 0 && clean_queue.size() == 0) begin
      $display("PASS text_comment_whitespace_filter_unit");
    end else begin
      $display("FAIL text_comment_whitespace_filter_unit");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAIL text_comment_whitespace_filter_unit");
    $finish;
  end

endmodule

/* filelist.f */
rtl/tcwf_pkg.sv
rtl/tcwf_if.sv
rtl/tcwf_core.sv
rtl/tcwf_burst.sv
rtl/text_comment_whitespace_filter_unit.sv
dv/text_comment_whitespace_filter_unit_tb.sv
